FILE: sv/arc_pkg.sv
// ----------------------------------------------------------------------------
// arc_pkg
// Shared types, field layout and constants of the repetition counter.
// ----------------------------------------------------------------------------
package arc_pkg;

    // field widths
    localparam int ACC_W   = 13;
    localparam int SQ_W    = 25;
    localparam int MAG_W   = 26;
    localparam int ADJ_W   = 8;
    localparam int LVL_W   = 26;
    localparam int CNT_W   = 16;
    localparam int CFG_D_W = 26;
    localparam int CFG_I_W = 2;

    // largest squared magnitude: three times 4096 squared
    localparam longint unsigned MAG_MAX = 64'd50331648;

    // register reset values and the count limit
    localparam logic [LVL_W-1:0] INIT_THR_RST    = 26'd0;
    localparam logic [LVL_W-1:0] QUIET_LEVEL_RST = 26'd1200000;
    localparam logic [CNT_W-1:0] QUIET_LIMIT_RST = 16'd750;
    localparam logic [CNT_W-1:0] CNT_MAX         = 16'hFFFF;

    // peak * 4 / 5: the 28-bit value (peak * 4) times ceil(2^31 / 5), shifted by 31
    localparam int SCALE_IN_W  = LVL_W + 2;
    localparam int SCALE_MUL_W = 29;
    localparam int SCALE_SH    = 31;
    localparam int SCALE_PROD_W = SCALE_IN_W + SCALE_MUL_W;
    localparam logic [SCALE_MUL_W-1:0] SCALE_MUL = 29'd429496730;

    // input tdata layout
    localparam int IN_TDATA_W = 48;
    localparam int IN_X_LSB    = 0;
    localparam int IN_Y_LSB    = 13;
    localparam int IN_Z_LSB    = 26;
    localparam int IN_ADJ_LSB  = 39;
    localparam int IN_STOP_BIT = 47;

    // output tdata layout
    localparam int OUT_TDATA_W    = 72;
    localparam int OUT_CNT_LSB    = 0;
    localparam int OUT_START_BIT  = 16;
    localparam int OUT_AVG_LSB    = 17;
    localparam int OUT_THR_LSB    = 43;
    localparam int OUT_PAD_LSB    = 69;
    localparam int OUT_PAD_W      = 3;

    typedef enum logic [CFG_I_W-1:0] {
        CFG_INIT_THR    = 2'd0,
        CFG_QUIET_LEVEL = 2'd1,
        CFG_QUIET_LIMIT = 2'd2
    } t_cfg_idx;

    // per-item side information that rides along the pipeline
    typedef struct packed {
        logic signed [ADJ_W-1:0] adj;
        logic                    stop;
        logic                    bar;
    } t_side;

endpackage

FILE: sv/arc_ram.sv
// ----------------------------------------------------------------------------
// arc_ram
// Generic single-port-write, single-port-read RAM with registered read data.
// ----------------------------------------------------------------------------
module arc_ram #(
    parameter int WIDTH  = 26,
    parameter int DEPTH  = 20,
    parameter int ADDR_W = 5
) (
    input  logic              i_clk,
    input  logic              i_we,
    input  logic [ADDR_W-1:0] i_waddr,
    input  logic [WIDTH-1:0]  i_wdata,
    input  logic              i_re,
    input  logic [ADDR_W-1:0] i_raddr,
    output logic [WIDTH-1:0]  o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

FILE: sv/accel_repetition_counter.sv
// ----------------------------------------------------------------------------
// accel_repetition_counter
// Counts exercise repetitions from accelerometer samples using a windowed
// mean of the squared magnitude against a peak-tracking threshold.
//
//   channel   | direction | handshake                  | payload
//   ----------+-----------+----------------------------+------------------------
//   s_axis    | in        | s_axis_tvalid/tready       | x, y, z, adjust, stop
//   m_axis    | out       | m_axis_tvalid/tready       | count, started, avg,
//             |           |                            | threshold; tlast=finished
//   cfg       | in        | i_cfg_valid/o_cfg_ready    | register index, data
//
// One sample per cycle while no output stall or held-off stop sample blocks
// input; the stages are squares, window sum, mean, peak, scaled peak, then
// the decision into the output register.
// The window lives in one RAM read once per sample at the oldest entry; each
// entry has a valid bit cleared by reset or by finishing, so no clear pass.
// An output stall freezes the whole pipeline and drops s_axis_tready.
// A sample with stop_enable whose quiet count could reach the limit holds off
// further input until it moves into the output register; an output stall prolongs the hold.
// ----------------------------------------------------------------------------
module accel_repetition_counter #(
    parameter int WINDOW_LEN = 20
) (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               s_axis_tvalid,
    output logic                               s_axis_tready,
    // [12:0] accel_x, [25:13] accel_y, [38:26] accel_z, [46:39] rep_adjust,
    // [47] stop_enable
    input  logic [arc_pkg::IN_TDATA_W-1:0]     s_axis_tdata,
    output logic                               m_axis_tvalid,
    input  logic                               m_axis_tready,
    // [15:0] rep_count, [16] rep_started, [42:17] average_level,
    // [68:43] active_threshold, [71:69] zero
    output logic [arc_pkg::OUT_TDATA_W-1:0]    m_axis_tdata,
    output logic                               m_axis_tlast,
    input  logic                               i_cfg_valid,
    output logic                               o_cfg_ready,
    input  logic [arc_pkg::CFG_I_W-1:0]        i_cfg_index,
    input  logic [arc_pkg::CFG_D_W-1:0]        i_cfg_data
);

    localparam int ADDR_W = (WINDOW_LEN > 1) ? $clog2(WINDOW_LEN) : 1;
    localparam longint unsigned SUM_MAX = longint'(WINDOW_LEN) * arc_pkg::MAG_MAX;
    localparam int SUM_W  = $clog2(SUM_MAX + 64'd1);
    localparam int DIV_SH = SUM_W + $clog2(WINDOW_LEN);
    localparam int MUL_W  = SUM_W + 1;
    localparam int PROD_W = 2 * SUM_W + 1;
    // exact floor division of any sum below 2^SUM_W by the window length
    localparam logic [MUL_W-1:0] DIV_MUL =
        MUL_W'(((64'd1 << DIV_SH) + 64'(WINDOW_LEN) - 64'd1) / 64'(WINDOW_LEN));
    localparam logic [ADDR_W-1:0] WP_LAST = ADDR_W'(WINDOW_LEN - 1);

    localparam int LW = arc_pkg::LVL_W;
    localparam int CW = arc_pkg::CNT_W;

    // configuration registers
    logic [LW-1:0] r_init_thr;
    logic [LW-1:0] r_quiet_lvl;
    logic [CW-1:0] r_quiet_lim;

    // block state
    logic [ADDR_W-1:0]     r_wp;
    logic [WINDOW_LEN-1:0] r_wvld;
    logic [SUM_W-1:0]      r_sum;
    logic [LW-1:0]         r_peak;
    logic [CW-1:0]         r_cnt;
    logic [CW-1:0]         r_quiet;
    logic                  r_inrep;

    // pipeline
    logic                  r_v1, r_v2, r_v3, r_v4, r_v5;
    arc_pkg::t_side        r_side1, r_side2, r_side3, r_side4, r_side5;
    logic [arc_pkg::SQ_W-1:0] r_sqx1, r_sqy1, r_sqz1;
    logic [ADDR_W-1:0]     r_addr1;
    logic                  r_old_vld1;
    logic [SUM_W-1:0]      r_sum2;
    logic [LW-1:0]         r_avg3, r_avg4, r_avg5;
    logic [LW-1:0]         r_peak4;
    logic [LW-1:0]         r_scaled5;

    // output register
    logic                           r_out_vld;
    logic [arc_pkg::OUT_TDATA_W-1:0] r_out_data;
    logic                           r_out_last;

    logic adv, acc, block, bar_in;
    logic [2:0] inflight;

    logic signed [arc_pkg::ACC_W-1:0] in_x, in_y, in_z;
    logic signed [2*arc_pkg::ACC_W-1:0] px, py, pz;
    arc_pkg::t_side side_in;

    logic [arc_pkg::MAG_W-1:0] mag, old_mag, ram_rdata;
    logic [SUM_W-1:0]          n_sum;
    logic [PROD_W-1:0]         div_prod;
    logic [LW-1:0]             avg2, n_peak;
    logic [arc_pkg::SCALE_PROD_W-1:0] scale_prod;
    logic [LW-1:0]             scaled4;

    logic [LW-1:0]        thr5;
    logic signed [CW+1:0] cnt_adj;
    logic [CW-1:0]        cnt_a, cnt_b, n_quiet;
    logic                 rise, fall, quiet_inc, n_inrep, fin;

    // ---------------------------------------------------------------- control
    assign adv      = !r_out_vld || m_axis_tready;
    assign inflight = 3'($countones({r_v1, r_v2, r_v3, r_v4, r_v5}));
    assign block    = (r_v1 && r_side1.bar) || (r_v2 && r_side2.bar) ||
                      (r_v3 && r_side3.bar) || (r_v4 && r_side4.bar) ||
                      (r_v5 && r_side5.bar);
    assign s_axis_tready = adv && !block;
    assign acc           = s_axis_tvalid && s_axis_tready;
    assign o_cfg_ready   = 1'b1;

    // ---------------------------------------------------------------- input
    assign in_x = s_axis_tdata[arc_pkg::IN_X_LSB +: arc_pkg::ACC_W];
    assign in_y = s_axis_tdata[arc_pkg::IN_Y_LSB +: arc_pkg::ACC_W];
    assign in_z = s_axis_tdata[arc_pkg::IN_Z_LSB +: arc_pkg::ACC_W];
    assign px   = in_x * in_x;
    assign py   = in_y * in_y;
    assign pz   = in_z * in_z;

    // upper bound of the quiet count after this sample; such a sample may
    // finish and reset the state, so later samples wait for it
    assign bar_in = s_axis_tdata[arc_pkg::IN_STOP_BIT] &&
                    ((18'(r_quiet) + 18'(inflight) + 18'd1) >= 18'(r_quiet_lim));

    always_comb begin
        side_in.adj  = s_axis_tdata[arc_pkg::IN_ADJ_LSB +: arc_pkg::ADJ_W];
        side_in.stop = s_axis_tdata[arc_pkg::IN_STOP_BIT];
        side_in.bar  = bar_in;
    end

    // ---------------------------------------------------------------- window
    // each entry is read one transfer after the previous one and written when
    // its sample leaves the first stage; an entry is rewritten only a full
    // window later, so read and write of the same entry never overlap
    arc_ram #(
        .WIDTH  (arc_pkg::MAG_W),
        .DEPTH  (WINDOW_LEN),
        .ADDR_W (ADDR_W)
    ) u_window (
        .i_clk   (i_clk),
        .i_we    (adv && r_v1),
        .i_waddr (r_addr1),
        .i_wdata (mag),
        .i_re    (acc),
        .i_raddr (r_wp),
        .o_rdata (ram_rdata)
    );

    assign mag     = arc_pkg::MAG_W'(r_sqx1) + arc_pkg::MAG_W'(r_sqy1) +
                     arc_pkg::MAG_W'(r_sqz1);
    assign old_mag = r_old_vld1 ? ram_rdata : '0;
    assign n_sum   = r_sum - SUM_W'(old_mag) + SUM_W'(mag);

    // ---------------------------------------------------------------- mean
    assign div_prod = PROD_W'(r_sum2) * PROD_W'(DIV_MUL);
    assign avg2     = div_prod[DIV_SH +: LW];

    assign n_peak = (r_avg3 > r_peak) ? r_avg3 : r_peak;

    assign scale_prod = arc_pkg::SCALE_PROD_W'({r_peak4, 2'b00}) *
                        arc_pkg::SCALE_PROD_W'(arc_pkg::SCALE_MUL);
    assign scaled4    = scale_prod[arc_pkg::SCALE_SH +: LW];

    // ---------------------------------------------------------------- decision
    always_comb begin
        thr5    = (r_init_thr >= r_scaled5) ? r_init_thr : r_scaled5;
        cnt_adj = signed'({2'b00, r_cnt}) + (CW+2)'(r_side5.adj);
        if (cnt_adj < 0) begin
            cnt_a = '0;
        end else if (cnt_adj > signed'({2'b00, arc_pkg::CNT_MAX})) begin
            cnt_a = arc_pkg::CNT_MAX;
        end else begin
            cnt_a = cnt_adj[CW-1:0];
        end
        rise  = (r_avg5 > thr5) && !r_inrep;
        fall  = (r_avg5 < thr5);
        cnt_b = (rise && cnt_a != arc_pkg::CNT_MAX) ? cnt_a + 1'b1 : cnt_a;
        quiet_inc = fall && (cnt_b != '0) && (r_avg5 < r_quiet_lvl) &&
                    (r_quiet != arc_pkg::CNT_MAX);
        n_quiet = quiet_inc ? r_quiet + 1'b1 : r_quiet;
        if (rise) begin
            n_inrep = 1'b1;
        end else if (fall) begin
            n_inrep = 1'b0;
        end else begin
            n_inrep = r_inrep;
        end
        fin = r_side5.stop && (n_quiet >= r_quiet_lim);
    end

    // ---------------------------------------------------------------- config
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_init_thr  <= arc_pkg::INIT_THR_RST;
            r_quiet_lvl <= arc_pkg::QUIET_LEVEL_RST;
            r_quiet_lim <= arc_pkg::QUIET_LIMIT_RST;
        end else if (i_cfg_valid) begin
            case (arc_pkg::t_cfg_idx'(i_cfg_index))
                arc_pkg::CFG_INIT_THR:    r_init_thr  <= i_cfg_data;
                arc_pkg::CFG_QUIET_LEVEL: r_quiet_lvl <= i_cfg_data;
                arc_pkg::CFG_QUIET_LIMIT: r_quiet_lim <= i_cfg_data[CW-1:0];
                default: ;
            endcase
        end
    end

    // ---------------------------------------------------------------- control regs
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1      <= 1'b0;
            r_v2      <= 1'b0;
            r_v3      <= 1'b0;
            r_v4      <= 1'b0;
            r_v5      <= 1'b0;
            r_out_vld <= 1'b0;
            r_wp      <= '0;
            r_wvld    <= '0;
            r_sum     <= '0;
            r_peak    <= '0;
            r_cnt     <= '0;
            r_quiet   <= '0;
            r_inrep   <= 1'b0;
        end else if (adv) begin
            r_v1      <= acc;
            r_v2      <= r_v1;
            r_v3      <= r_v2;
            r_v4      <= r_v3;
            r_v5      <= r_v4;
            r_out_vld <= r_v5;
            if (acc) begin
                r_wp <= (r_wp == WP_LAST) ? '0 : r_wp + 1'b1;
            end
            if (r_v1) begin
                r_sum           <= n_sum;
                r_wvld[r_addr1] <= 1'b1;
            end
            if (r_v3) begin
                r_peak <= n_peak;
            end
            if (r_v5) begin
                // set over: everything ahead has drained, back to reset state
                if (fin) begin
                    r_wp    <= '0;
                    r_wvld  <= '0;
                    r_sum   <= '0;
                    r_peak  <= '0;
                    r_cnt   <= '0;
                    r_quiet <= '0;
                    r_inrep <= 1'b0;
                end else begin
                    r_cnt   <= cnt_b;
                    r_quiet <= n_quiet;
                    r_inrep <= n_inrep;
                end
            end
        end
    end

    // ---------------------------------------------------------------- payload regs
    always_ff @(posedge i_clk) begin
        if (adv) begin
            r_sqx1     <= px[arc_pkg::SQ_W-1:0];
            r_sqy1     <= py[arc_pkg::SQ_W-1:0];
            r_sqz1     <= pz[arc_pkg::SQ_W-1:0];
            r_side1    <= side_in;
            r_addr1    <= r_wp;
            r_old_vld1 <= r_wvld[r_wp];

            r_sum2  <= n_sum;
            r_side2 <= r_side1;

            r_avg3  <= avg2;
            r_side3 <= r_side2;

            r_avg4  <= r_avg3;
            r_peak4 <= n_peak;
            r_side4 <= r_side3;

            r_avg5    <= r_avg4;
            r_scaled5 <= scaled4;
            r_side5   <= r_side4;

            if (r_v5) begin
                r_out_data <= {{arc_pkg::OUT_PAD_W{1'b0}}, thr5, r_avg5, rise, cnt_b};
                r_out_last <= fin;
            end
        end
    end

    assign m_axis_tvalid = r_out_vld;
    assign m_axis_tdata  = r_out_data;
    assign m_axis_tlast  = r_out_last;

endmodule

FILE: sv/arc_chk.sv
// ----------------------------------------------------------------------------
// arc_chk
// Port-level checks of the repetition counter, bound to the top level.
// ----------------------------------------------------------------------------
module arc_chk (
    input logic                            i_clk,
    input logic                            i_rst_n,
    input logic                            s_axis_tready,
    input logic                            m_axis_tvalid,
    input logic                            m_axis_tready,
    input logic [arc_pkg::OUT_TDATA_W-1:0] m_axis_tdata,
    input logic                            m_axis_tlast
);

    logic [arc_pkg::LVL_W-1:0] avg, thr;
    logic [arc_pkg::CNT_W-1:0] cnt;
    logic                      started;

    assign avg     = m_axis_tdata[arc_pkg::OUT_AVG_LSB +: arc_pkg::LVL_W];
    assign thr     = m_axis_tdata[arc_pkg::OUT_THR_LSB +: arc_pkg::LVL_W];
    assign cnt     = m_axis_tdata[arc_pkg::OUT_CNT_LSB +: arc_pkg::CNT_W];
    assign started = m_axis_tdata[arc_pkg::OUT_START_BIT];

    // a stalled result holds until its transfer
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tready |=>
            m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tlast))
        else $error("result changed while stalled");

    // the pipeline freezes as a whole, so a stalled output blocks input
    a_stall_in: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tready |-> !s_axis_tready)
        else $error("input taken while output stalled");

    // a new repetition means a crossing and a nonzero count
    a_start: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && started |-> (avg > thr) && (cnt != '0))
        else $error("repetition start without crossing");

    a_rst: assert property (@(posedge i_clk)
        !i_rst_n |=> !m_axis_tvalid)
        else $error("output valid right after reset");

endmodule

bind accel_repetition_counter arc_chk u_arc_chk (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .s_axis_tready (s_axis_tready),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tlast  (m_axis_tlast)
);
